// File: rtl/swdq_pkg.sv
// ----------------------------------------------------------------------------
// swdq_pkg
// Types, constants and channel remap functions of the input qualifier.
// ----------------------------------------------------------------------------
package swdq_pkg;

  localparam int CHANNELS = 9;
  localparam int PIN_W    = 9;
  localparam int PHYS_W   = 11;
  localparam int MAP_LEN  = 9;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MIN_W    = 6;

  typedef logic [PIN_W-1:0]  pins_t;
  typedef logic [PHYS_W-1:0] phys_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_MODE = 2'd0,
    REG_PULSE_MIN  = 2'd1,
    REG_POLARITY   = 2'd2,
    REG_ENABLE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             pulse_sel;
    logic [MIN_W-1:0] pulse_min;
  } chan_cfg_t;

  localparam logic [3:0] MAP_PHYS [MAP_LEN] = '{
    4'd0, 4'd1, 4'd4, 4'd5, 4'd6, 4'd10, 4'd8, 4'd9, 4'd7
  };

  function automatic phys_t to_physical(input pins_t logical);
    phys_t r;
    r = '0;
    for (int k = 0; k < MAP_LEN; k++) begin
      if (logical[k]) begin
        r[MAP_PHYS[k]] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic pins_t to_logical(input phys_t physical);
    pins_t r;
    r = '0;
    for (int k = 0; k < MAP_LEN; k++) begin
      r[k] = physical[MAP_PHYS[k]];
    end
    return r;
  endfunction

endpackage

// File: rtl/swdq_in_if.sv
// ----------------------------------------------------------------------------
// swdq_in_if
// Sample channel: one word carries one sample of the raw input pins.
// ----------------------------------------------------------------------------
interface swdq_in_if import swdq_pkg::*;;
  logic  valid;
  logic  ready;
  pins_t raw_pins;

  modport source (output valid, output raw_pins, input ready);
  modport sink (input valid, input raw_pins, output ready);
endinterface

// File: rtl/swdq_out_if.sv
// ----------------------------------------------------------------------------
// swdq_out_if
// Status channel: one word carries the qualified status of one sample.
// ----------------------------------------------------------------------------
interface swdq_out_if import swdq_pkg::*;;
  logic  valid;
  logic  ready;
  pins_t channel_status;
  pins_t filtered_levels;

  modport source (output valid, output channel_status, output filtered_levels, input ready);
  modport sink (input valid, input channel_status, input filtered_levels, output ready);
endinterface

// File: rtl/swdq_cell.sv
// ----------------------------------------------------------------------------
// swdq_cell
// One stage of the sample window: holds one sample and passes it on.
// ----------------------------------------------------------------------------
module swdq_cell import swdq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  pins_t d,
  output pins_t q
);

  pins_t sample_r;
  pins_t sample_nxt;

  always_comb begin
    sample_nxt = shift_en ? d : sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  assign q = sample_r;

endmodule

// File: rtl/swdq_chan.sv
// ----------------------------------------------------------------------------
// swdq_chan
// Per-channel high-sample counter over the window and its level classifier.
// ----------------------------------------------------------------------------
module swdq_chan import swdq_pkg::*; #(
  parameter int WINDOW = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      upd_en,
  input  logic      new_bit,
  input  logic      old_bit,
  input  chan_cfg_t cfg,
  output logic      level_nxt
);

  localparam int CW          = $clog2(WINDOW + 1);
  localparam int MW          = (CW > MIN_W) ? CW : MIN_W;
  localparam int LEVEL_LIMIT = WINDOW - (WINDOW / 4);
  localparam bit PULSE_OK    = (WINDOW >= 15);
  localparam int PULSE_HI    = PULSE_OK ? (WINDOW - 15) : 0;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] count_upd;
  logic          level_on;
  logic          pulse_on;

  always_comb begin
    count_upd = count_r + CW'(new_bit) - CW'(old_bit);
    count_nxt = upd_en ? count_upd : count_r;
    level_on  = count_upd < CW'(LEVEL_LIMIT);
    pulse_on  = PULSE_OK && (count_upd <= CW'(PULSE_HI)) &&
                (MW'(count_upd) >= MW'(cfg.pulse_min));
    level_nxt = cfg.pulse_sel ? pulse_on : level_on;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/windowed_digital_input_qualifier.sv
// ----------------------------------------------------------------------------
// windowed_digital_input_qualifier
// Sliding-window debounce and qualification of nine digital input pins.
// ----------------------------------------------------------------------------
// Each word on in_word is one sample of the raw pins. The block keeps the
// last WINDOW samples in a chain of cells and a running count of high samples
// per pin. Every sample produces one word on out_word with the classified
// level per physical pin and the polarity-adjusted, masked status in logical
// channel order. The cfg port writes the pulse mode, pulse minimum, polarity
// and enable registers; write them only while no word is in flight.
// The status word of an accepted sample is valid in the next cycle, and one
// sample is taken every cycle while out_word does not stall. The count update
// and its classification share the cycle in which the sample shifts into the
// cell chain. The result sits in an output register; in_word.ready is high
// when that register is empty or being taken, so a stalled receiver holds the
// word and stalls the sampler one-for-one. Synchronous reset clears the
// window, the counts, the configuration registers and the output valid.
// ----------------------------------------------------------------------------
module windowed_digital_input_qualifier import swdq_pkg::*; #(
  parameter int WINDOW = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  swdq_in_if.sink              in_word,
  swdq_out_if.source           out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pins_t            pulse_mode_r;
  logic [MIN_W-1:0] pulse_min_r;
  pins_t            polarity_r;
  pins_t            enable_r;

  logic  out_valid_r;
  pins_t status_r;
  pins_t levels_r;
  pins_t status_nxt;
  pins_t levels_nxt;

  logic  accept;
  pins_t sample;
  pins_t taps [WINDOW+1];
  phys_t pulse_phys;
  phys_t pol_phys;
  phys_t en_phys;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;
  assign sample        = in_word.raw_pins;
  assign taps[0]       = sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_mode_r <= '0;
      pulse_min_r  <= '0;
      polarity_r   <= '0;
      enable_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PULSE_MODE: pulse_mode_r <= cfg_data[PIN_W-1:0];
        REG_PULSE_MIN:  pulse_min_r  <= cfg_data[MIN_W-1:0];
        REG_POLARITY:   polarity_r   <= cfg_data[PIN_W-1:0];
        REG_ENABLE:     enable_r     <= cfg_data[PIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  for (genvar s = 0; s < WINDOW; s++) begin : g_cell
    swdq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .d        (taps[s]),
      .q        (taps[s+1])
    );
  end

  assign pulse_phys = to_physical(pulse_mode_r);
  assign pol_phys   = to_physical(polarity_r);
  assign en_phys    = to_physical(enable_r);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    chan_cfg_t chan_cfg;

    assign chan_cfg.pulse_sel = pulse_phys[c];
    assign chan_cfg.pulse_min = pulse_min_r;

    swdq_chan #(
      .WINDOW (WINDOW)
    ) u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd_en    (accept),
      .new_bit   (sample[c]),
      .old_bit   (taps[WINDOW][c]),
      .cfg       (chan_cfg),
      .level_nxt (levels_nxt[c])
    );
  end

  always_comb begin
    status_nxt = to_logical(~(PHYS_W'(levels_nxt) ^ pol_phys) & en_phys);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      out_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      levels_r <= levels_nxt;
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.channel_status  = status_r;
  assign out_word.filtered_levels = levels_r;

endmodule

// File: rtl/swdq_checker.sv
// ----------------------------------------------------------------------------
// swdq_checker
// Port-level checks of the input qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module swdq_checker import swdq_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input pins_t channel_status,
  input pins_t filtered_levels
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted sample produced no status word");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(channel_status) && $stable(filtered_levels)))
    else $error("stalled status word changed");

endmodule

bind windowed_digital_input_qualifier swdq_checker u_swdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_word.valid),
  .in_ready        (in_word.ready),
  .out_valid       (out_word.valid),
  .out_ready       (out_word.ready),
  .channel_status  (out_word.channel_status),
  .filtered_levels (out_word.filtered_levels)
);

// File: bench/windowed_digital_input_qualifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_digital_input_qualifier_tb
// Self-checking bench for the sliding-window input qualifier.
// ----------------------------------------------------------------------------
// A short table of samples and register writes comes first. Then several
// register settings follow, each with a stream of pin samples built from runs
// of steady levels and noise, so that every count crosses the level and
// pulse thresholds. A local window model predicts each status word that the
// table does not give, and both channels stall at random.
// ----------------------------------------------------------------------------
module windowed_digital_input_qualifier_tb;
  import swdq_pkg::*;

  localparam int WINDOW      = 50;
  localparam int LEVEL_LIMIT = WINDOW - WINDOW / 4;
  localparam int PULSE_HI    = WINDOW - 15;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 100;
  localparam int IDLE_LIMIT  = 4000;
  localparam int NUM_STEPS   = 34;
  localparam logic [3:0] LOGIC_TO_PHYS [CHANNELS] = '{
    4'd0, 4'd1, 4'd4, 4'd5, 4'd6, 4'd10, 4'd8, 4'd9, 4'd7
  };

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t kind;
    cfg_reg_t   reg_sel;
    logic [8:0] value;
    bit         typed;
    pins_t      exp_status;
    pins_t      exp_levels;
  } step_t;

  typedef struct packed {
    pins_t channel_status;
    pins_t filtered_levels;
  } status_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  swdq_in_if  in_if ();
  swdq_out_if out_if ();

  windowed_digital_input_qualifier #(.WINDOW(WINDOW)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_if),
    .out_word  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pins_t            win_ring [WINDOW];
  int               win_pos;
  int               hi_count [CHANNELS];
  pins_t            mdl_pulse_sel;
  logic [MIN_W-1:0] mdl_pulse_min;
  pins_t            mdl_polarity;
  pins_t            mdl_enable;

  status_word_t status_q [$];
  step_t        steps [NUM_STEPS];

  bit           in_fire;
  bit           out_fire;
  bit           cfg_fire;
  status_word_t out_seen;
  int           fail_count;
  int           words_sent;
  int           words_checked;
  int           writes_done;
  int           idle_cycles;
  bit           src_no_gaps;
  int           run_left;
  pins_t        run_hi;
  pins_t        run_noise;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic phys_t spread_logical(pins_t logical);
    phys_t r;
    r = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (logical[k]) begin
        r[LOGIC_TO_PHYS[k]] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic status_word_t qualify_sample(pins_t raw);
    status_word_t w;
    pins_t        oldest;
    phys_t        pulse_p;
    phys_t        pol_p;
    phys_t        en_p;
    phys_t        lev;
    phys_t        st;
    oldest = win_ring[win_pos];
    for (int i = 0; i < CHANNELS; i++) begin
      hi_count[i] = hi_count[i] - int'(oldest[i]) + int'(raw[i]);
    end
    win_ring[win_pos] = raw;
    win_pos = (win_pos == WINDOW - 1) ? 0 : win_pos + 1;
    pulse_p = spread_logical(mdl_pulse_sel);
    pol_p   = spread_logical(mdl_polarity);
    en_p    = spread_logical(mdl_enable);
    lev = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (pulse_p[i]) begin
        lev[i] = (hi_count[i] <= PULSE_HI) && (hi_count[i] >= int'(mdl_pulse_min));
      end else begin
        lev[i] = hi_count[i] < LEVEL_LIMIT;
      end
    end
    st = ~(lev ^ pol_p) & en_p;
    for (int k = 0; k < CHANNELS; k++) begin
      w.channel_status[k] = st[LOGIC_TO_PHYS[k]];
    end
    w.filtered_levels = lev[PIN_W-1:0];
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic pins_t next_sample();
    int r;
    if (run_left == 0) begin
      r = $urandom_range(0, 9);
      run_hi = pins_t'($urandom);
      if (r < 4) run_noise = '0;
      else if (r < 8) run_noise = pins_t'($urandom & $urandom);
      else run_noise = '1;
      run_left = $urandom_range(8, 90);
    end
    run_left--;
    return (run_hi & ~run_noise) | (pins_t'($urandom) & run_noise);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(negedge clk) begin
    in_fire  = in_if.valid && in_if.ready;
    out_fire = out_if.valid && out_if.ready;
    cfg_fire = cfg_we;
    out_seen.channel_status  = out_if.channel_status;
    out_seen.filtered_levels = out_if.filtered_levels;
  end

  always @(posedge clk) begin
    status_word_t exp_w;
    if (out_fire) begin
      if (status_q.size() == 0) begin
        note_failure($sformatf("unexpected word status=%03h levels=%03h",
                               out_seen.channel_status, out_seen.filtered_levels));
      end else begin
        exp_w = status_q.pop_front();
        words_checked++;
        if (exp_w.channel_status !== out_seen.channel_status) begin
          note_failure($sformatf("channel_status expected %03h actual %03h",
                                 exp_w.channel_status, out_seen.channel_status));
        end
        if (exp_w.filtered_levels !== out_seen.filtered_levels) begin
          note_failure($sformatf("filtered_levels expected %03h actual %03h",
                                 exp_w.filtered_levels, out_seen.filtered_levels));
        end
      end
    end
    if (in_fire || out_fire || cfg_fire || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words pending",
               IDLE_LIMIT, status_q.size());
      $display("[windowed_digital_input_qualifier] ERROR");
      $finish;
    end
  end

  task automatic send_sample(pins_t p, bit typed, status_word_t typed_w);
    status_word_t w;
    int           gap;
    gap = src_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.raw_pins <= p;
    do @(posedge clk); while (!in_fire);
    w = qualify_sample(p);
    status_q.push_back(typed ? typed_w : w);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [8:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      REG_PULSE_MODE: mdl_pulse_sel = v;
      REG_PULSE_MIN:  mdl_pulse_min = v[MIN_W-1:0];
      REG_POLARITY:   mdl_polarity = v;
      REG_ENABLE:     mdl_enable = v;
      default:        ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    writes_done++;
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int len;
      int gap;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      out_if.ready <= 1'b1;
      repeat (len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    status_word_t typed_w;
    logic [8:0]   pm;
    logic [8:0]   pmin;
    logic [8:0]   pol;
    logic [8:0]   en;
    steps = '{
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1FF, 1'b1, 9'h000, 9'h1FF},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h000, 1'b1, 9'h000, 9'h1FF},
      '{STEP_WRITE,  REG_ENABLE,     9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h155, 1'b1, 9'h0A0, 9'h1FF},
      '{STEP_WRITE,  REG_POLARITY,   9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h0AA, 1'b1, 9'h15F, 9'h1FF},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_POLARITY,   9'h000, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_PULSE_MODE, 9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_PULSE_MIN,  9'd63,  1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h000, 1'b1, 9'h1FF, 9'h00C},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_PULSE_MIN,  9'd51,  1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h123, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_PULSE_MIN,  9'd0,   1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_PULSE_MODE, 9'h0F0, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_ENABLE,     9'h0A0, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_POLARITY,   9'h020, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h000, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_PULSE_MIN,  9'd2,   1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_ENABLE,     9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_POLARITY,   9'h155, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h0F0, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h10F, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1FF, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h000, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h1A5, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h05A, 1'b0, 9'h000, 9'h000},
      '{STEP_WRITE,  REG_PULSE_MODE, 9'h000, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h0C3, 1'b0, 9'h000, 9'h000},
      '{STEP_SAMPLE, REG_PULSE_MODE, 9'h13C, 1'b0, 9'h000, 9'h000}
    };

    for (int i = 0; i < WINDOW; i++) win_ring[i] = '0;
    for (int i = 0; i < CHANNELS; i++) hi_count[i] = 0;
    win_pos       = 0;
    mdl_pulse_sel = '0;
    mdl_pulse_min = '0;
    mdl_polarity  = '0;
    mdl_enable    = '0;
    fail_count    = 0;
    words_sent    = 0;
    words_checked = 0;
    writes_done   = 0;
    idle_cycles   = 0;
    src_no_gaps   = 1'b0;
    run_left      = 0;

    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.raw_pins <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int s = 0; s < NUM_STEPS; s++) begin
      if (steps[s].kind == STEP_WRITE) begin
        wait_idle();
        write_reg(steps[s].reg_sel, steps[s].value);
      end else begin
        typed_w.channel_status  = steps[s].exp_status;
        typed_w.filtered_levels = steps[s].exp_levels;
        send_sample(steps[s].value, steps[s].typed, typed_w);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin pm = 9'h000; pmin = 9'd0;  pol = 9'h000; en = 9'h1FF; end
        1: begin pm = 9'h1FF; pmin = 9'd35; pol = 9'h1FF; en = 9'h1FF; end
        2: begin pm = 9'h1FF; pmin = 9'd63; pol = 9'h000; en = 9'h1FF; end
        3: begin pm = 9'h000; pmin = 9'd50; pol = 9'h1FF; en = 9'h000; end
        default: begin
          pm   = 9'($urandom);
          pmin = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 50))
                                            : 9'($urandom_range(51, 63));
          pol  = 9'($urandom);
          en   = 9'($urandom);
        end
      endcase
      wait_idle();
      write_reg(REG_PULSE_MODE, pm);
      write_reg(REG_PULSE_MIN, pmin);
      write_reg(REG_POLARITY, pol);
      write_reg(REG_ENABLE, en);
      src_no_gaps = (ph == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 4 && n == PHASE_WORDS / 2) wait_drained();
        send_sample(next_sample(), 1'b0, typed_w);
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (status_q.size() != 0) begin
      note_failure($sformatf("%0d expected words never arrived", status_q.size()));
    end
    $display("Sent %0d samples and checked %0d status words over %0d register writes,",
             words_sent, words_checked, writes_done);
    $display("with %0d register settings after the table; %0d mismatches.",
             NUM_PHASES, fail_count);
    if (fail_count == 0) begin
      $display("[windowed_digital_input_qualifier] OK");
    end else begin
      $display("[windowed_digital_input_qualifier] ERROR");
    end
    $finish;
  end

endmodule
